@@ design/tlj_pkg.sv @@
// ---------------------------------------------------------------------------
// Text line justifier package
// Shared widths, payload types, the line descriptor and the width clamp.
// ---------------------------------------------------------------------------
package tlj_pkg;

   localparam int MAX_WIDTH   = 32;
   localparam int CHAR_W      = 8;
   localparam int CFG_W       = 6;
   localparam int POS_W       = $clog2(MAX_WIDTH + 1);
   localparam int IDX_W       = $clog2(MAX_WIDTH);
   localparam int GAP_W       = $clog2(MAX_WIDTH / 2 + 1);
   localparam int LINE_DEPTH  = 2 * MAX_WIDTH;
   localparam int LADDR_W     = $clog2(LINE_DEPTH);
   localparam int QUEUE_DEPTH = 2;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int OUT_DEPTH   = 4;
   localparam int OCNT_W      = $clog2(OUT_DEPTH + 1);
   localparam int OPTR_W      = $clog2(OUT_DEPTH);

   localparam logic [CHAR_W-1:0] SPACE_CHAR  = 8'h20;
   localparam logic [CFG_W-1:0]  WIDTH_RESET = CFG_W'(MAX_WIDTH);

   typedef struct packed {
      logic [CHAR_W-1:0] in_char;
      logic              word_end;
      logic              text_end;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic              line_end;
   } rsp_type;

   // One packed line waiting in a line buffer.
   typedef struct packed {
      logic                 buf_sel;
      logic [POS_W-1:0]     len;
      logic [MAX_WIDTH-1:0] gap_mask;
      logic [GAP_W-1:0]     gap_count;
      logic                 justify;
   } line_desc_type;

   typedef struct packed {
      logic               en;
      logic [LADDR_W-1:0] addr;
      logic [CHAR_W-1:0]  data;
   } line_wr_type;

   // Zero acts as one, anything above the built maximum acts as the maximum.
   function automatic logic [POS_W-1:0] eff_width(input logic [CFG_W-1:0] w);
      logic [POS_W-1:0] r;
      if (w == '0) begin
         r = POS_W'(1);
      end else if (w > CFG_W'(MAX_WIDTH)) begin
         r = POS_W'(MAX_WIDTH);
      end else begin
         r = POS_W'(w);
      end
      return r;
   endfunction

endpackage

@@ design/tlj_ram.sv @@
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module tlj_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/tlj_line_queue.sv @@
// ---------------------------------------------------------------------------
// Line descriptor queue
// Holds finished lines between the packer and the emitter. An entry stays at
// the head until its line has been fully emitted, so it also tracks buffer use.
// ---------------------------------------------------------------------------
module tlj_line_queue
   import tlj_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  line_desc_type push_desc,
   input  logic          pop,
   output logic [QCNT_W-1:0] count,
   output line_desc_type head
);

   line_desc_type      slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      cnt_in    = QCNT_W'(cnt_ff + QCNT_W'(push) - QCNT_W'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

   assign count = cnt_ff;
   assign head  = slot_ff[rd_ptr_ff];

endmodule

@@ design/tlj_front.sv @@
// ---------------------------------------------------------------------------
// Line packer
// Collects word characters, decides where each finished word goes, copies it
// into the line buffer under construction and hands finished lines on.
// ---------------------------------------------------------------------------
module tlj_front
   import tlj_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [POS_W-1:0]  width,
   input  logic              push,
   output logic              full,
   input  req_type           req_data,
   input  logic [QCNT_W-1:0] q_count,
   output logic              q_push,
   output line_desc_type     q_push_desc,
   output line_wr_type       line_wr
);

   localparam logic [1:0] F_ACCEPT = 2'd0;
   localparam logic [1:0] F_FLUSH  = 2'd1;
   localparam logic [1:0] F_COPY   = 2'd2;
   localparam logic [1:0] F_FINAL  = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [POS_W-1:0]     wl_ff, wl_in;
   logic [POS_W-1:0]     ll_ff, ll_in;
   logic [MAX_WIDTH-1:0] gmask_ff, gmask_in;
   logic [GAP_W-1:0]     gcnt_ff, gcnt_in;
   logic                 holds_ff, holds_in;
   logic                 bsel_ff, bsel_in;
   logic [POS_W-1:0]     cp_ff, cp_in;
   logic [POS_W-1:0]     clen_ff, clen_in;
   logic [IDX_W-1:0]     dest_ff, dest_in;
   logic                 te_ff, te_in;
   logic                 wv_ff, wv_in;
   logic [LADDR_W-1:0]   wa_ff, wa_in;

   logic               accept;
   logic               wr_word;
   logic [POS_W-1:0]   wl_new;
   logic [POS_W:0]     fit_sum;
   logic               fits;
   logic               buf_free;
   logic               copy_issue;
   logic [CHAR_W-1:0]  word_rd_data;

   assign full     = (state_ff != F_ACCEPT);
   assign accept   = push && !full;
   assign wr_word  = accept && (wl_ff < width);
   assign wl_new   = POS_W'(wl_ff + POS_W'(wl_ff < width));
   assign fit_sum  = {1'b0, ll_ff} + (POS_W + 1)'(1) + {1'b0, wl_new};
   assign fits     = holds_ff && (fit_sum <= {1'b0, width});
   // The buffer being built is free whenever the queue does not hold both.
   assign buf_free = (q_count < QCNT_W'(QUEUE_DEPTH));

   always_comb begin
      state_in    = state_ff;
      wl_in       = wl_ff;
      ll_in       = ll_ff;
      gmask_in    = gmask_ff;
      gcnt_in     = gcnt_ff;
      holds_in    = holds_ff;
      bsel_in     = bsel_ff;
      cp_in       = cp_ff;
      clen_in     = clen_ff;
      dest_in     = dest_ff;
      te_in       = te_ff;
      copy_issue  = 1'b0;
      q_push      = 1'b0;
      q_push_desc = '{buf_sel: bsel_ff, len: ll_ff, gap_mask: gmask_ff,
                      gap_count: gcnt_ff, justify: 1'b1};
      unique case (state_ff)
         F_ACCEPT: begin
            if (accept) begin
               wl_in = wl_new;
               if (req_data.word_end || req_data.text_end) begin
                  wl_in   = '0;
                  clen_in = wl_new;
                  cp_in   = '0;
                  te_in   = req_data.text_end;
                  if (fits) begin
                     dest_in                     = IDX_W'(ll_ff + 1'b1);
                     gmask_in[ll_ff[IDX_W-1:0]]  = 1'b1;
                     gcnt_in                     = GAP_W'(gcnt_ff + 1'b1);
                     ll_in                       = POS_W'(fit_sum);
                     state_in                    = F_COPY;
                  end else if (holds_ff) begin
                     state_in = F_FLUSH;
                  end else begin
                     dest_in  = '0;
                     ll_in    = wl_new;
                     gmask_in = '0;
                     gcnt_in  = '0;
                     holds_in = 1'b1;
                     state_in = F_COPY;
                  end
               end
            end
         end
         F_FLUSH: begin
            if (buf_free) begin
               q_push   = 1'b1;
               bsel_in  = ~bsel_ff;
               dest_in  = '0;
               ll_in    = clen_ff;
               gmask_in = '0;
               gcnt_in  = '0;
               holds_in = 1'b1;
               state_in = F_COPY;
            end
         end
         F_COPY: begin
            if (buf_free) begin
               copy_issue = 1'b1;
               cp_in      = POS_W'(cp_ff + 1'b1);
               if (POS_W'(cp_ff + 1'b1) == clen_ff) begin
                  state_in = te_ff ? F_FINAL : F_ACCEPT;
               end
            end
         end
         F_FINAL: begin
            if (buf_free) begin
               q_push              = 1'b1;
               q_push_desc.justify = 1'b0;
               bsel_in             = ~bsel_ff;
               ll_in               = '0;
               gmask_in            = '0;
               gcnt_in             = '0;
               holds_in            = 1'b0;
               state_in            = F_ACCEPT;
            end
         end
      endcase
   end

   // Word memory reads are registered; line writes are delayed to match.
   assign wv_in = copy_issue;
   assign wa_in = {bsel_ff, IDX_W'(dest_ff + cp_ff[IDX_W-1:0])};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_ACCEPT;
         wl_ff    <= '0;
         ll_ff    <= '0;
         gmask_ff <= '0;
         gcnt_ff  <= '0;
         holds_ff <= 1'b0;
         bsel_ff  <= 1'b0;
         wv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         wl_ff    <= wl_in;
         ll_ff    <= ll_in;
         gmask_ff <= gmask_in;
         gcnt_ff  <= gcnt_in;
         holds_ff <= holds_in;
         bsel_ff  <= bsel_in;
         wv_ff    <= wv_in;
      end
   end

   always_ff @(posedge clock) begin
      cp_ff   <= cp_in;
      clen_ff <= clen_in;
      dest_ff <= dest_in;
      te_ff   <= te_in;
      wa_ff   <= wa_in;
   end

   tlj_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (MAX_WIDTH)
   ) u_word_ram (
      .clock   (clock),
      .wr_en   (wr_word),
      .wr_addr (wl_ff[IDX_W-1:0]),
      .wr_data (req_data.in_char),
      .rd_addr (cp_ff[IDX_W-1:0]),
      .rd_data (word_rd_data)
   );

   assign line_wr = '{en: wv_ff, addr: wa_ff, data: word_rd_data};

endmodule

@@ design/tlj_back.sv @@
// ---------------------------------------------------------------------------
// Line emitter
// Takes the line at the head of the queue, splits the padding over its gaps
// with a bit-serial divider and streams the line into a small output queue.
// ---------------------------------------------------------------------------
module tlj_back
   import tlj_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [POS_W-1:0]   width,
   input  logic [QCNT_W-1:0]  q_count,
   input  line_desc_type      q_head,
   output logic               q_pop,
   output logic [LADDR_W-1:0] line_rd_addr,
   input  logic [CHAR_W-1:0]  line_rd_data,
   output logic               empty,
   input  logic               pop,
   output rsp_type            rsp_data
);

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_DIV  = 2'd1;
   localparam logic [1:0] B_EMIT = 2'd2;
   localparam int STEP_W = $clog2(POS_W + 1);

   logic [1:0]         bstate_ff, bstate_in;
   logic [POS_W-1:0]   div_ff, div_in;
   logic [GAP_W-1:0]   rem_ff, rem_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [POS_W-1:0]   idx_ff, idx_in;
   logic [GAP_W-1:0]   g_ff, g_in;
   logic [POS_W-1:0]   sp_ff, sp_in;
   logic               bv_ff, bv_in;
   logic               bspace_ff, bspace_in;
   logic               bend_ff, bend_in;

   rsp_type            ofifo_ff [OUT_DEPTH];
   logic [OPTR_W-1:0]  owr_ff, ord_ff;
   logic [OCNT_W-1:0]  ocnt_ff;

   logic [POS_W-1:0]   pad;
   logic [GAP_W:0]     rem_sh;
   logic               q_bit;
   logic               adv;
   logic               last;
   logic               out_pop;

   assign pad    = (q_head.len < width) ? POS_W'(width - q_head.len) : '0;
   assign rem_sh = {rem_ff, div_ff[POS_W-1]};
   assign q_bit  = (rem_sh >= {1'b0, q_head.gap_count});
   // Room is reserved for the character still in flight from the line memory.
   assign adv    = (OCNT_W'(ocnt_ff + OCNT_W'(bv_ff)) < OCNT_W'(OUT_DEPTH));
   assign last   = (pos_ff == POS_W'(width - 1'b1));

   always_comb begin
      bstate_in = bstate_ff;
      div_in    = div_ff;
      rem_in    = rem_ff;
      step_in   = step_ff;
      pos_in    = pos_ff;
      idx_in    = idx_ff;
      g_in      = g_ff;
      sp_in     = sp_ff;
      bv_in     = 1'b0;
      bspace_in = 1'b1;
      bend_in   = last;
      q_pop     = 1'b0;
      unique case (bstate_ff)
         B_IDLE: begin
            pos_in = '0;
            idx_in = '0;
            g_in   = '0;
            sp_in  = '0;
            if (q_count != '0) begin
               if (q_head.justify && (q_head.gap_count != '0)) begin
                  div_in    = pad;
                  rem_in    = '0;
                  step_in   = STEP_W'(POS_W);
                  bstate_in = B_DIV;
               end else begin
                  div_in    = '0;
                  rem_in    = '0;
                  bstate_in = B_EMIT;
               end
            end
         end
         B_DIV: begin
            // Restoring division, one quotient bit per cycle.
            div_in  = {div_ff[POS_W-2:0], q_bit};
            rem_in  = q_bit ? GAP_W'(rem_sh - {1'b0, q_head.gap_count})
                            : GAP_W'(rem_sh);
            step_in = STEP_W'(step_ff - 1'b1);
            if (step_ff == STEP_W'(1)) begin
               bstate_in = B_EMIT;
            end
         end
         B_EMIT: begin
            if (adv) begin
               bv_in  = 1'b1;
               pos_in = POS_W'(pos_ff + 1'b1);
               if (sp_ff != '0) begin
                  sp_in = POS_W'(sp_ff - 1'b1);
               end else if (idx_ff < q_head.len) begin
                  idx_in = POS_W'(idx_ff + 1'b1);
                  if (q_head.gap_mask[idx_ff[IDX_W-1:0]]) begin
                     // This separator is widened: quotient plus one while the
                     // remainder lasts; the separator itself goes out now.
                     sp_in = POS_W'(div_ff + POS_W'(g_ff < rem_ff));
                     g_in  = GAP_W'(g_ff + 1'b1);
                  end else begin
                     bspace_in = 1'b0;
                  end
               end
               if (last) begin
                  q_pop     = 1'b1;
                  bstate_in = B_IDLE;
               end
            end
         end
         default: begin
            bstate_in = B_IDLE;
         end
      endcase
   end

   assign line_rd_addr = {q_head.buf_sel, idx_ff[IDX_W-1:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         bstate_ff <= B_IDLE;
         bv_ff     <= 1'b0;
      end else begin
         bstate_ff <= bstate_in;
         bv_ff     <= bv_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff    <= div_in;
      rem_ff    <= rem_in;
      step_ff   <= step_in;
      pos_ff    <= pos_in;
      idx_ff    <= idx_in;
      g_ff      <= g_in;
      sp_ff     <= sp_in;
      bspace_ff <= bspace_in;
      bend_ff   <= bend_in;
   end

   // Output queue.
   assign out_pop = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         owr_ff  <= '0;
         ord_ff  <= '0;
         ocnt_ff <= '0;
      end else begin
         if (bv_ff) begin
            owr_ff <= OPTR_W'(owr_ff + 1'b1);
         end
         if (out_pop) begin
            ord_ff <= OPTR_W'(ord_ff + 1'b1);
         end
         ocnt_ff <= OCNT_W'(ocnt_ff + OCNT_W'(bv_ff) - OCNT_W'(out_pop));
      end
   end

   always_ff @(posedge clock) begin
      if (bv_ff) begin
         ofifo_ff[owr_ff] <= '{out_char: bspace_ff ? SPACE_CHAR : line_rd_data,
                               line_end: bend_ff};
      end
   end

   assign empty    = (ocnt_ff == '0);
   assign rsp_data = ofifo_ff[ord_ff];

endmodule

@@ design/text_line_full_justifier.sv @@
// ---------------------------------------------------------------------------
// Text line full justifier
// Packs word characters greedily into lines of the configured width and
// emits them one character per transaction, fully justified but for a text's last line.
//
// Input queue: push a character with req_data while full is low; word_end
// marks the last character of a word, text_end the last one of the text.
// Result queue: while empty is low rsp_data holds the oldest character, pop
// takes it; line_end marks the last character of every line.
// csr_wr_en with csr_wr_data sets the line width; write it only while idle.
// After the last character of a word the packer copies it from the word
// memory into the line buffer, with a flush step for each line that it
// closes; full stays high meanwhile.
// A justified line is handed over in the flush step after the word that
// closes it is taken; a bit-serial divide then splits the padding, and one
// character leaves per cycle while the output queue has room. A line with
// no gaps, or a text's last line, skips the divide. Two line buffers let
// one line be emitted while the next builds.
// When the receiver stalls, the 4-entry output queue fills, the emitter
// holds, and full rises once both line buffers are taken.
// Reset empties all queues and sets the width to 32; no clearing pass.
// ---------------------------------------------------------------------------
module text_line_full_justifier
   import tlj_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  req_type           req_data,
   output logic              empty,
   input  logic              pop,
   output rsp_type           rsp_data,
   input  logic              csr_wr_en,
   input  logic [CFG_W-1:0]  csr_wr_data
);

   logic [CFG_W-1:0]   width_ff;
   logic [POS_W-1:0]   width;
   logic [QCNT_W-1:0]  q_count;
   logic               q_push;
   logic               q_pop;
   line_desc_type      q_push_desc;
   line_desc_type      q_head;
   line_wr_type        line_wr;
   logic [LADDR_W-1:0] line_rd_addr;
   logic [CHAR_W-1:0]  line_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
      end else if (csr_wr_en) begin
         width_ff <= csr_wr_data;
      end
   end

   assign width = eff_width(width_ff);

   tlj_front u_front (
      .clock       (clock),
      .reset       (reset),
      .width       (width),
      .push        (push),
      .full        (full),
      .req_data    (req_data),
      .q_count     (q_count),
      .q_push      (q_push),
      .q_push_desc (q_push_desc),
      .line_wr     (line_wr)
   );

   tlj_line_queue u_line_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (q_push_desc),
      .pop       (q_pop),
      .count     (q_count),
      .head      (q_head)
   );

   tlj_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (LINE_DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (line_wr.en),
      .wr_addr (line_wr.addr),
      .wr_data (line_wr.data),
      .rd_addr (line_rd_addr),
      .rd_data (line_rd_data)
   );

   tlj_back u_back (
      .clock        (clock),
      .reset        (reset),
      .width        (width),
      .q_count      (q_count),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .line_rd_addr (line_rd_addr),
      .line_rd_data (line_rd_data),
      .empty        (empty),
      .pop          (pop),
      .rsp_data     (rsp_data)
   );

endmodule

@@ design/tlj_checker.sv @@
// ---------------------------------------------------------------------------
// Text line justifier checker
// Watches the ports: every emitted line is exactly the configured width long.
// ---------------------------------------------------------------------------
module tlj_checker
   import tlj_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             empty,
   input logic             pop,
   input rsp_type          rsp_data,
   input logic             csr_wr_en,
   input logic [CFG_W-1:0] csr_wr_data
);

   logic [CFG_W-1:0] width_ff;
   logic [POS_W-1:0] cnt_ff;
   logic [POS_W-1:0] cnt_next;
   logic             taken;

   assign taken    = pop && !empty;
   assign cnt_next = POS_W'(cnt_ff + 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
      end else if (csr_wr_en) begin
         width_ff <= csr_wr_data;
      end
   end

   // Characters of the current line already taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (taken) begin
         cnt_ff <= rsp_data.line_end ? '0 : cnt_next;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");

   a_line_full_length: assert property (@(posedge clock) disable iff (reset)
      (taken && rsp_data.line_end) |-> (cnt_next == eff_width(width_ff)))
      else $error("line ended at the wrong length");

   a_line_not_long: assert property (@(posedge clock) disable iff (reset)
      (taken && !rsp_data.line_end) |-> (cnt_next < eff_width(width_ff)))
      else $error("line ran past the configured width");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("waiting result changed or vanished");

endmodule

bind text_line_full_justifier tlj_checker u_checker (.*);

@@ sim/text_line_full_justifier_tb.sv @@
// ---------------------------------------------------------------------------
// Text line full justifier testbench
// Streams word characters through the justifier under random sender gaps and
// receiver stalls, predicts every output character of every line,
// and checks each popped character in order. The run steps through several
// line widths, the out-of-range widths among them, and width changes
// while a line is held.
// ---------------------------------------------------------------------------
module text_line_full_justifier_tb;
   import tlj_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 120;
   localparam int QUIET_LIMIT   = 2000;
   localparam int PHASE_COUNT   = 8;
   localparam int PHASE_CHARS   = 30;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             push = 1'b0;
   logic             full;
   req_type          req_data = '0;
   logic             empty;
   logic             pop = 1'b0;
   rsp_type          rsp_data;
   logic             csr_wr_en = 1'b0;
   logic [CFG_W-1:0] csr_wr_data = '0;

   text_line_full_justifier dut (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_data    (req_data),
      .empty       (empty),
      .pop         (pop),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   req_type chars_to_send[$];
   rsp_type expected_chars[$];
   int      chars_queued = 0;
   int      chars_taken = 0;
   int      send_idle_max = 10;
   int      recv_idle_max = 10;
   int      send_wait = 0;
   int      recv_wait = 0;
   int      quiet_cycles = 0;
   int      fail_count = 0;

   // Mirror of the block: the word being collected and the line being packed.
   logic [CFG_W-1:0]     width_reg = WIDTH_RESET;
   logic [CHAR_W-1:0]    word_chars [MAX_WIDTH];
   logic [CHAR_W-1:0]    line_chars [MAX_WIDTH];
   logic [MAX_WIDTH-1:0] sep_mask = '0;
   int                   word_len = 0;
   int                   line_len = 0;
   int                   gap_total = 0;
   bit                   line_busy = 1'b0;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int active_width();
      int w;
      w = int'(width_reg);
      if (w < 1) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
   endfunction

   task automatic append_char(input logic [CHAR_W-1:0] c, input bit last);
      rsp_type item;
      item.out_char = c;
      item.line_end = last;
      expected_chars = {expected_chars, item};
   endtask

   // Every line comes out exactly one width long; a line held from a wider
   // setting is cut short instead of padded.
   task automatic flush_line(input bit justify);
      int w, pad, per, more, pos, g, cnt;
      w = active_width();
      pad = (line_len < w) ? w - line_len : 0;
      per = 0;
      more = 0;
      pos = 0;
      g = 0;
      if (justify && gap_total > 0) begin
         per = pad / gap_total;
         more = pad % gap_total;
      end
      for (int i = 0; i < line_len && i < MAX_WIDTH && pos < w; i++) begin
         if (sep_mask[i]) begin
            cnt = 1 + per + ((g < more) ? 1 : 0);
            g++;
            for (int c = 0; c < cnt && pos < w; c++) begin
               append_char(SPACE_CHAR, pos == w - 1);
               pos++;
            end
         end else begin
            append_char(line_chars[i], pos == w - 1);
            pos++;
         end
      end
      while (pos < w) begin
         append_char(SPACE_CHAR, pos == w - 1);
         pos++;
      end
   endtask

   task automatic pack_char(input req_type item);
      int w;
      w = active_width();
      if (word_len < w && word_len < MAX_WIDTH) begin
         word_chars[word_len] = item.in_char;
         word_len++;
      end
      if (item.word_end || item.text_end) begin
         if (line_busy && line_len + 1 + word_len <= w) begin
            line_chars[line_len] = SPACE_CHAR;
            sep_mask[line_len] = 1'b1;
            line_len++;
            for (int k = 0; k < word_len; k++) line_chars[line_len + k] = word_chars[k];
            line_len += word_len;
            gap_total++;
         end else begin
            if (line_busy) flush_line(1'b1);
            for (int k = 0; k < word_len; k++) line_chars[k] = word_chars[k];
            line_len = word_len;
            sep_mask = '0;
            gap_total = 0;
            line_busy = 1'b1;
         end
         word_len = 0;
      end
      if (item.text_end) begin
         if (line_busy) flush_line(1'b0);
         line_len = 0;
         sep_mask = '0;
         gap_total = 0;
         line_busy = 1'b0;
      end
   endtask

   // Sender: one character per transaction, with a random gap before each.
   always @(posedge clock) begin : drive_chars
      logic next_push;
      if (reset) begin
         push <= 1'b0;
         send_wait = 0;
      end else begin
         next_push = push;
         if (push && !full) begin
            pack_char(req_data);
            chars_taken++;
            next_push = 1'b0;
         end
         if (!next_push) begin
            if (send_wait > 0) begin
               send_wait--;
            end else if (chars_to_send.size() != 0) begin
               req_data <= chars_to_send.pop_front();
               next_push = 1'b1;
               send_wait = $urandom_range(send_idle_max, 0);
            end
         end
         push <= next_push;
      end
   end

   // Receiver: checks each popped character, then stalls a random while.
   always @(posedge clock) begin : take_chars
      rsp_type want;
      if (reset) begin
         pop <= 1'b0;
         recv_wait = 0;
      end else begin
         if (pop && !empty) begin
            if (expected_chars.size() == 0) begin
               $error("unexpected output character %h", rsp_data.out_char);
               fail_count++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_data.out_char !== want.out_char) begin
                  $error("out_char: expected %h, got %h", want.out_char, rsp_data.out_char);
                  fail_count++;
               end
               if (rsp_data.line_end !== want.line_end) begin
                  $error("line_end: expected %b, got %b", want.line_end, rsp_data.line_end);
                  fail_count++;
               end
            end
            recv_wait = $urandom_range(recv_idle_max, 0);
         end
         if (recv_wait > 0) begin
            recv_wait--;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("FAILED: results differ");
      $finish;
   end

   task automatic queue_char(input logic [CHAR_W-1:0] c, input bit w_end, input bit t_end);
      req_type item;
      item.in_char = c;
      item.word_end = w_end;
      item.text_end = t_end;
      chars_to_send = {chars_to_send, item};
      chars_queued++;
   endtask

   task automatic queue_word(input int len, input bit t_end);
      for (int k = 0; k < len; k++) begin
         queue_char(CHAR_W'($urandom_range(255, 0)), k == len - 1, t_end && k == len - 1);
      end
   endtask

   // Waits until every queued character is taken and every line
   // has come out, then lets the block settle.
   task automatic drain();
      while (chars_taken != chars_queued) @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_width(input logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      width_reg = value;
   endtask

   initial begin
      logic [CFG_W-1:0] phase_widths [PHASE_COUNT];
      int               phase_end, n_words, len;
      bit               leave_open;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: a one-character text, extreme and space characters, a
      // held line cut by a narrower width, an overlong word, and a word on
      // the text end that pushes out two lines at once.
      queue_char(8'hFF, 1'b1, 1'b1);
      queue_char(8'h00, 1'b0, 1'b0);
      queue_char(SPACE_CHAR, 1'b1, 1'b0);
      queue_char(8'hFF, 1'b1, 1'b0);
      queue_word(3, 1'b1);
      queue_word(2, 1'b0);
      queue_word(2, 1'b0);
      drain();
      write_width(CFG_W'(4));
      queue_word(6, 1'b1);
      queue_word(1, 1'b0);
      queue_word(1, 1'b0);
      queue_word(2, 1'b1);
      drain();

      phase_widths[0] = CFG_W'(0);
      phase_widths[1] = CFG_W'(63);
      phase_widths[2] = CFG_W'(1);
      phase_widths[3] = CFG_W'(32);
      phase_widths[4] = CFG_W'(33);
      for (int p = 5; p < PHASE_COUNT; p++) phase_widths[p] = CFG_W'($urandom_range(31, 2));

      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_width(phase_widths[p]);
         send_idle_max = (p % 4 == 1 || p % 4 == 2) ? 0 : 10;
         recv_idle_max = (p % 4 == 1 || p % 4 == 3) ? 0 : 10;
         phase_end = chars_queued + PHASE_CHARS;
         while (chars_queued < phase_end) begin
            n_words = $urandom_range(12, 1);
            for (int i = 0; i < n_words; i++) begin
               len = ($urandom_range(15, 0) == 0) ? $urandom_range(40, 1)
                                                  : $urandom_range(7, 1);
               if ($urandom_range(9, 0) == 0) begin
                  // Broken sequence: flags drawn at random.
                  for (int k = 0; k < len; k++) begin
                     queue_char(CHAR_W'($urandom_range(255, 0)), 1'($urandom_range(1, 0)),
                                1'($urandom_range(1, 0)));
                  end
               end else begin
                  queue_word(len, i == n_words - 1);
               end
            end
         end
         // End on a word boundary; sometimes keep the line held so that the
         // next width applies to it.
         leave_open = ($urandom_range(2, 0) == 0);
         queue_word($urandom_range(5, 1), !leave_open);
         drain();
      end

      if (fail_count == 0 && expected_chars.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
